[hw/rtl/assert_macros.svh]
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CHK_IMPLY(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that holds on every rising clock edge outside reset.
`define CHK_ALWAYS(label, cond, msg) \
    `CHK_IMPLY(label, 1'b1, cond, msg)

`endif

[hw/rtl/v3n_pkg.sv]
// Types and pipeline constants of the 3D vector normalize core.
package v3n_pkg;

    localparam int COMP_W      = 32;
    localparam int MAG_W       = 32;
    localparam int SUM_W       = 64;
    localparam int DIV_STAGES  = 63;
    localparam int SQRT_STAGES = 32;
    localparam int RAD_W       = 64;
    localparam int REM_W       = 36;
    localparam int ROOT_W      = 32;
    localparam int SUM_STAGE   = 3;
    localparam int LATENCY     = SUM_STAGE + DIV_STAGES + SQRT_STAGES + 1;
    localparam int LANE_DEPTH  = LATENCY - 1;
    localparam int ZERO_DEPTH  = LATENCY - SUM_STAGE;

    typedef logic [SUM_W-1:0]      t_sum;
    typedef logic [DIV_STAGES-1:0] t_quot;
    typedef logic [ROOT_W-1:0]     t_root;

endpackage

[hw/rtl/vector3_normalize_core.sv]
// Top level of the 3D vector normalize core: three lanes and the merging stage.
//
// Usage:
//   Drive i_comp_x/y/z (signed Q16.16) and raise start; the request is taken
//   at a rising edge with start high and busy low. busy is low whenever the
//   block is out of reset, so a new request may enter on every cycle.
//   Each request yields one result: o_done is high for one
//   cycle with o_unit_x/y/z (signed Q2.30, rounded to nearest, ties away
//   from zero) and o_zero_length. A zero vector gives zero components and
//   o_zero_length high.
//   Throughput is one request per cycle. The lane pipeline holds registers for
//   magnitude, square and sum, 63 long-division stages (one quotient bit
//   each), 32 square-root stages (one root bit each) and one output
//   register.
//   Reset (synchronous, active low) drops all requests in flight; busy is
//   high while reset is held. The receiver cannot stall: results are shown
//   for exactly one cycle.
module vector3_normalize_core import v3n_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic signed [COMP_W-1:0] i_comp_x,
    input  logic signed [COMP_W-1:0] i_comp_y,
    input  logic signed [COMP_W-1:0] i_comp_z,
    output logic                     o_done,
    output logic signed [COMP_W-1:0] o_unit_x,
    output logic signed [COMP_W-1:0] o_unit_y,
    output logic signed [COMP_W-1:0] o_unit_z,
    output logic                     o_zero_length
);

    t_sum  w_sq_x, w_sq_y, w_sq_z;
    t_root w_root_x, w_root_y, w_root_z;
    logic  w_neg_x, w_neg_y, w_neg_z;
    t_sum  n_sum;
    t_sum  r_sum;
    logic  r_zero [ZERO_DEPTH];
    logic  r_vld  [LATENCY];

    function automatic logic [COMP_W-1:0] unit_of(input t_root root, input logic neg,
                                                  input logic zero);
        logic [ROOT_W:0]    half_up;
        logic [COMP_W-1:0]  mag;
        half_up = {1'b0, root} + 1'b1;
        mag     = COMP_W'(half_up[ROOT_W:1]);
        if (zero) begin
            return '0;
        end
        return neg ? (~mag + 1'b1) : mag;
    endfunction

    assign busy = ~i_rst_n;

    v3n_lane u_lane_x (
        .i_clk  (i_clk),
        .i_comp (i_comp_x),
        .i_sum  (r_sum),
        .o_sq   (w_sq_x),
        .o_root (w_root_x),
        .o_neg  (w_neg_x)
    );

    v3n_lane u_lane_y (
        .i_clk  (i_clk),
        .i_comp (i_comp_y),
        .i_sum  (r_sum),
        .o_sq   (w_sq_y),
        .o_root (w_root_y),
        .o_neg  (w_neg_y)
    );

    v3n_lane u_lane_z (
        .i_clk  (i_clk),
        .i_comp (i_comp_z),
        .i_sum  (r_sum),
        .o_sq   (w_sq_z),
        .o_root (w_root_z),
        .o_neg  (w_neg_z)
    );

    // each square is at most 2^62, so the sum of three fits
    assign n_sum = w_sq_x + w_sq_y + w_sq_z;

    always_ff @(posedge i_clk) begin
        r_sum     <= n_sum;
        r_zero[0] <= (n_sum == '0);
        for (int k = 1; k < ZERO_DEPTH; k++) begin
            r_zero[k] <= r_zero[k-1];
        end
        o_unit_x      <= unit_of(w_root_x, w_neg_x, r_zero[ZERO_DEPTH-1]);
        o_unit_y      <= unit_of(w_root_y, w_neg_y, r_zero[ZERO_DEPTH-1]);
        o_unit_z      <= unit_of(w_root_z, w_neg_z, r_zero[ZERO_DEPTH-1]);
        o_zero_length <= r_zero[ZERO_DEPTH-1];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < LATENCY; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start & ~busy;
            for (int k = 1; k < LATENCY; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    assign o_done = r_vld[LATENCY-1];

endmodule

[hw/rtl/v3n_lane.sv]
// One component lane: magnitude, square, long division by the sum, square root.
module v3n_lane import v3n_pkg::*; (
    input  logic                     i_clk,
    input  logic signed [COMP_W-1:0] i_comp,
    input  t_sum                     i_sum,
    output t_sum                     o_sq,
    output t_root                    o_root,
    output logic                     o_neg
);

    logic [MAG_W-1:0] n_mag;
    logic [MAG_W-1:0] r_mag;
    t_sum             r_sq;
    t_sum             r_sq_d;
    logic             r_neg_dly [LANE_DEPTH];

    t_sum             r_div_rem [DIV_STAGES-1];
    t_sum             r_div_sum [DIV_STAGES-1];
    t_quot            r_div_q   [DIV_STAGES];

    logic [REM_W-1:0] r_sr_rem  [SQRT_STAGES-1];
    logic [RAD_W-1:0] r_sr_rad  [SQRT_STAGES-1];
    t_root            r_sr_root [SQRT_STAGES];

    assign n_mag = i_comp[COMP_W-1] ? (~i_comp + 1'b1) : i_comp;

    always_ff @(posedge i_clk) begin
        r_mag        <= n_mag;
        r_sq         <= SUM_W'(r_mag) * SUM_W'(r_mag);
        r_sq_d       <= r_sq;
        r_neg_dly[0] <= i_comp[COMP_W-1];
        for (int k = 1; k < LANE_DEPTH; k++) begin
            r_neg_dly[k] <= r_neg_dly[k-1];
        end
    end

    // quotient of sq * 2^62 / sum, one bit per stage, msb first
    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_div
        logic [SUM_W:0] w_trial;
        logic [SUM_W:0] w_diff;
        t_sum           w_sum;
        t_quot          w_q;
        logic           w_ge;

        if (j == 0) begin : g_first
            assign w_trial = {1'b0, r_sq_d};
            assign w_sum   = i_sum;
            assign w_q     = '0;
        end else begin : g_next
            assign w_trial = {r_div_rem[j-1], 1'b0};
            assign w_sum   = r_div_sum[j-1];
            assign w_q     = r_div_q[j-1];
        end

        assign w_ge   = w_trial >= {1'b0, w_sum};
        assign w_diff = w_trial - {1'b0, w_sum};

        always_ff @(posedge i_clk) begin
            r_div_q[j] <= {w_q[DIV_STAGES-2:0], w_ge};
        end

        if (j < DIV_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_div_rem[j] <= w_ge ? w_diff[SUM_W-1:0] : w_trial[SUM_W-1:0];
                r_div_sum[j] <= w_sum;
            end
        end
    end

    // integer square root of the quotient, two radicand bits per stage
    for (genvar i = 0; i < SQRT_STAGES; i++) begin : g_sqrt
        logic [REM_W-1:0] w_rem_in;
        logic [RAD_W-1:0] w_rad_in;
        t_root            w_root_in;
        logic [REM_W-1:0] w_cur;
        logic [REM_W-1:0] w_try;
        logic             w_ge;

        if (i == 0) begin : g_first
            assign w_rem_in  = '0;
            assign w_rad_in  = {1'b0, r_div_q[DIV_STAGES-1]};
            assign w_root_in = '0;
        end else begin : g_next
            assign w_rem_in  = r_sr_rem[i-1];
            assign w_rad_in  = r_sr_rad[i-1];
            assign w_root_in = r_sr_root[i-1];
        end

        assign w_cur = {w_rem_in[REM_W-3:0], w_rad_in[RAD_W-1:RAD_W-2]};
        assign w_try = REM_W'({w_root_in, 2'b01});
        assign w_ge  = w_cur >= w_try;

        always_ff @(posedge i_clk) begin
            r_sr_root[i] <= {w_root_in[ROOT_W-2:0], w_ge};
        end

        if (i < SQRT_STAGES - 1) begin : g_carry
            always_ff @(posedge i_clk) begin
                r_sr_rem[i] <= w_ge ? (w_cur - w_try) : w_cur;
                r_sr_rad[i] <= {w_rad_in[RAD_W-3:0], 2'b00};
            end
        end
    end

    assign o_sq   = r_sq;
    assign o_root = r_sr_root[SQRT_STAGES-1];
    assign o_neg  = r_neg_dly[LANE_DEPTH-1];

endmodule

[hw/rtl/v3n_checker.sv]
// Port-level checks of the 3D vector normalize core, bound to the top level.
`include "assert_macros.svh"

module v3n_checker import v3n_pkg::*; (
    input logic                     i_clk,
    input logic                     i_rst_n,
    input logic                     start,
    input logic                     busy,
    input logic                     o_done,
    input logic signed [COMP_W-1:0] o_unit_x,
    input logic signed [COMP_W-1:0] o_unit_y,
    input logic signed [COMP_W-1:0] o_unit_z,
    input logic                     o_zero_length
);

    logic w_took;
    logic w_all_zero;
    logic w_in_range;

    function automatic logic in_unit(input logic signed [COMP_W-1:0] v);
        return v >= -32'sd1073741824 && v <= 32'sd1073741824;
    endfunction

    assign w_took     = start && !busy;
    assign w_all_zero = o_unit_x == 0 && o_unit_y == 0 && o_unit_z == 0;
    assign w_in_range = in_unit(o_unit_x) && in_unit(o_unit_y) && in_unit(o_unit_z);

    `CHK_IMPLY(a_done_has_request, o_done, $past(w_took, LATENCY), "result without request")
    `CHK_IMPLY(a_zero_clears, o_done && o_zero_length, w_all_zero, "zero vector unit not zero")
    `CHK_IMPLY(a_unit_nonzero, o_done && !o_zero_length, !w_all_zero, "unit vector all zero")
    `CHK_ALWAYS(a_unit_range, !o_done || w_in_range, "unit out of range")

endmodule

bind vector3_normalize_core v3n_checker u_v3n_checker (.*);

[tb/sv/vector3_normalize_core_test.sv]
// Testbench for the 3D vector normalize core: directed table, random vectors, scoreboard.
`timescale 1ns / 100ps

module vector3_normalize_core_test;
    import v3n_pkg::*;

    localparam int ITEMS_RANDOM = 525;
    localparam int WATCHDOG_MAX = 4000;
    localparam int DRAIN_WAIT   = LATENCY + 10;

    typedef logic signed [COMP_W-1:0] t_comp;

    typedef struct {
        t_comp unit_x;
        t_comp unit_y;
        t_comp unit_z;
        logic  zero_length;
    } t_unit_vec;

    typedef struct {
        t_comp     x;
        t_comp     y;
        t_comp     z;
        logic      known;
        t_unit_vec want;
    } t_vec_row;

    logic  i_clk;
    logic  i_rst_n;
    logic  start;
    logic  busy;
    t_comp i_comp_x, i_comp_y, i_comp_z;
    logic  o_done;
    t_comp o_unit_x, o_unit_y, o_unit_z;
    logic  o_zero_length;

    t_unit_vec unit_q[$];
    logic      took;
    logic      failed;
    int        idle_cycles;

    vector3_normalize_core uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .start(start), .busy(busy),
        .i_comp_x(i_comp_x), .i_comp_y(i_comp_y), .i_comp_z(i_comp_z),
        .o_done(o_done), .o_unit_x(o_unit_x), .o_unit_y(o_unit_y),
        .o_unit_z(o_unit_z), .o_zero_length(o_zero_length)
    );

    always begin
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
        #4;
    end

    function automatic logic [63:0] comp_mag(t_comp c);
        logic [32:0] m;
        m = c[31] ? (33'h1_0000_0000 - {1'b0, c}) : {1'b0, c};
        return {31'b0, m};
    endfunction

    // Round |c| * 2^30 / sqrt(sum) to nearest by bisection on k - 1/2.
    function automatic t_comp unit_part(t_comp c, logic [63:0] sum);
        logic [63:0]  m, m_sq, lo, hi, mid, odd;
        logic [127:0] lhs, rhs;
        m    = comp_mag(c);
        m_sq = m * m;
        lo   = 0;
        hi   = 64'h4000_0000;
        lhs  = {64'b0, m_sq} << 62;
        while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            odd = 2 * mid - 1;
            rhs = {64'b0, odd * odd} * {64'b0, sum};
            if (lhs >= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        if (c[31]) begin
            lo = 64'd0 - lo;
        end
        return lo[31:0];
    endfunction

    function automatic t_unit_vec normalize(t_comp x, t_comp y, t_comp z);
        t_unit_vec   r;
        logic [63:0] mx, my, mz, sum;
        mx  = comp_mag(x);
        my  = comp_mag(y);
        mz  = comp_mag(z);
        sum = mx * mx + my * my + mz * mz;
        if (sum == 0) begin
            r = '{0, 0, 0, 1'b1};
        end else begin
            r = '{unit_part(x, sum), unit_part(y, sum), unit_part(z, sum), 1'b0};
        end
        return r;
    endfunction

    function automatic t_comp rand_comp();
        int    kind;
        t_comp v;
        kind = $urandom_range(0, 9);
        v    = $urandom;
        case (kind)
            0, 1, 2: v = $urandom;
            3:       v = $urandom_range(0, 16) - 8;
            4, 5:    v = v >>> $urandom_range(1, 31);
            6:       v = 0;
            7:       v = $urandom_range(0, 1) ? 32'sh7fff_ffff : 32'sh8000_0000;
            default: v = v >>> $urandom_range(8, 20);
        endcase
        return v;
    endfunction

    function automatic int rand_gap();
        int pick;
        pick = $urandom_range(0, 19);
        if (pick < 13) begin
            return 0;
        end else if (pick < 19) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Accepted requests and results, both seen at the rising edge.
    always @(posedge i_clk) begin
        t_unit_vec want;
        took = start && !busy && i_rst_n;
        if (took) begin
            unit_q.push_back(normalize(i_comp_x, i_comp_y, i_comp_z));
        end
        if (o_done && i_rst_n) begin
            if (unit_q.size() == 0) begin
                $display("%0t: unexpected result x=%0d y=%0d z=%0d zl=%0b", $time,
                         o_unit_x, o_unit_y, o_unit_z, o_zero_length);
                failed = 1'b1;
            end else begin
                want = unit_q.pop_front();
                if (o_unit_x !== want.unit_x) begin
                    $display("%0t: unit_x expected %0d actual %0d", $time, want.unit_x, o_unit_x);
                    failed = 1'b1;
                end
                if (o_unit_y !== want.unit_y) begin
                    $display("%0t: unit_y expected %0d actual %0d", $time, want.unit_y, o_unit_y);
                    failed = 1'b1;
                end
                if (o_unit_z !== want.unit_z) begin
                    $display("%0t: unit_z expected %0d actual %0d", $time, want.unit_z, o_unit_z);
                    failed = 1'b1;
                end
                if (o_zero_length !== want.zero_length) begin
                    $display("%0t: zero_length expected %0b actual %0b", $time,
                             want.zero_length, o_zero_length);
                    failed = 1'b1;
                end
            end
        end
        idle_cycles = (took || o_done) ? 0 : idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_MAX) begin
            $display("status: fail");
            $finish;
        end
    end

    // Hold the request until taken; start stays high into the next request.
    task automatic send_vec(t_comp x, t_comp y, t_comp z, int gap);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        start    <= 1'b1;
        i_comp_x <= x;
        i_comp_y <= y;
        i_comp_z <= z;
        @(negedge i_clk);
        while (!took) @(negedge i_clk);
    endtask

    t_vec_row vec_table[] = '{
        '{0, 0, 0, 1'b1, '{0, 0, 0, 1'b1}},
        '{32'sh0001_0000, 0, 0, 1'b1, '{32'sh4000_0000, 0, 0, 1'b0}},
        '{0, -32'sh0001_0000, 0, 1'b1, '{0, -32'sh4000_0000, 0, 1'b0}},
        '{0, 0, 1, 1'b1, '{0, 0, 32'sh4000_0000, 1'b0}},
        '{32'sh8000_0000, 0, 0, 1'b1, '{32'shc000_0000, 0, 0, 1'b0}},
        '{0, 32'sh7fff_ffff, 0, 1'b1, '{0, 32'sh4000_0000, 0, 1'b0}},
        '{0, 0, 32'sh8000_0000, 1'b1, '{0, 0, 32'shc000_0000, 1'b0}},
        '{-1, 0, 0, 1'b1, '{32'shc000_0000, 0, 0, 1'b0}},
        '{32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'sh7fff_ffff, 32'sh8000_0000, 32'sh7fff_ffff, 1'b0, '{0, 0, 0, 1'b0}},
        '{3, 4, 0, 1'b0, '{0, 0, 0, 1'b0}},
        '{-2, 1, -2, 1'b0, '{0, 0, 0, 1'b0}},
        '{1, 1, 1, 1'b0, '{0, 0, 0, 1'b0}},
        '{1, 32'sh7fff_ffff, 0, 1'b0, '{0, 0, 0, 1'b0}},
        '{-1, 32'sh8000_0000, 1, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'sh5555_5555, -32'sh2aaa_aaab, 32'sh0f0f_0f0f, 1'b0, '{0, 0, 0, 1'b0}},
        '{32'shffff_fffe, 32'sh0000_0001, 32'sh0000_0002, 1'b0, '{0, 0, 0, 1'b0}}
    };

    initial begin
        t_unit_vec calc;
        int        burst;
        failed      = 1'b0;
        took        = 1'b0;
        idle_cycles = 0;
        i_rst_n     = 1'b0;
        start       = 1'b0;
        i_comp_x    = 0;
        i_comp_y    = 0;
        i_comp_z    = 0;
        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Typed-in rows cross-check the predictor itself.
        foreach (vec_table[i]) begin
            if (vec_table[i].known) begin
                calc = normalize(vec_table[i].x, vec_table[i].y, vec_table[i].z);
                if (calc != vec_table[i].want) begin
                    $display("%0t: row %0d expected %0d %0d %0d %0b actual %0d %0d %0d %0b",
                             $time, i, vec_table[i].want.unit_x, vec_table[i].want.unit_y,
                             vec_table[i].want.unit_z, vec_table[i].want.zero_length,
                             calc.unit_x, calc.unit_y, calc.unit_z, calc.zero_length);
                    failed = 1'b1;
                end
            end
            send_vec(vec_table[i].x, vec_table[i].y, vec_table[i].z, (i % 4 == 3) ? 2 : 0);
        end

        // Pause until everything in flight has come out.
        start <= 1'b0;
        @(negedge i_clk);
        while (unit_q.size() != 0) @(negedge i_clk);

        burst = 0;
        for (int n = 0; n < ITEMS_RANDOM; n++) begin
            // Alternate idle-free bursts with gappy stretches.
            if ((n / 40) % 3 == 1) begin
                burst = 0;
            end else begin
                burst = rand_gap();
            end
            send_vec(rand_comp(), rand_comp(), rand_comp(), burst);
        end
        start <= 1'b0;
        @(negedge i_clk);
        while (unit_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        if (!failed && unit_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
